FILE: hw/rtl/rfpd_pkg.sv
// Shared types and constants for the feedback RC4 packet decrypt unit.
// Holds operation codes, channel payload structs and the built-in key table.
// No dependencies.
package rfpd_pkg;

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_START   = 2'd1;
  localparam logic [1:0] OP_DECRYPT = 2'd2;

  localparam int BOX_DEPTH = 256;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] table_index;
    logic [7:0] data_byte;
    logic       last;
  } rfpd_in_t;

  typedef struct packed {
    logic [7:0] plain_byte;
    logic       last_byte;
  } rfpd_out_t;

  // key table contents after reset
  localparam logic [7:0] KEY_RESET_TABLE [0:BOX_DEPTH-1] = '{
    8'h4B, 8'h8C, 8'h96, 8'h62, 8'h0C, 8'h29, 8'hEF, 8'h43, 8'h0E,
    8'h7D, 8'h7A, 8'h46, 8'hB9, 8'h56, 8'h00, 8'h5F, 8'h68,
    8'h2F, 8'h47, 8'h31, 8'hA1, 8'h81, 8'h4D, 8'h55, 8'h92, 8'h88,
    8'h5B, 8'hB5, 8'hA5, 8'h30, 8'h8D, 8'h08, 8'h19, 8'h63,
    8'h9D, 8'hE0, 8'h42, 8'hDA, 8'hEE, 8'hCA, 8'h3F, 8'h6B, 8'h5E,
    8'h7E, 8'h71, 8'hCB, 8'h5A, 8'hF3, 8'h06, 8'h0D, 8'h66,
    8'h41, 8'hEA, 8'h8B, 8'hEC, 8'hB0, 8'h10, 8'h28, 8'h93, 8'h8A,
    8'h05, 8'h1C, 8'hC1, 8'hF2, 8'hF5, 8'h7B, 8'h4E, 8'hB3,
    8'h18, 8'h70, 8'hB8, 8'h65, 8'hAA, 8'h74, 8'hA3, 8'hBA, 8'hA0,
    8'h82, 8'h6F, 8'hDD, 8'h53, 8'hDB, 8'hBF, 8'h02, 8'h36,
    8'h32, 8'hF6, 8'h94, 8'h16, 8'h8F, 8'h6E, 8'h86, 8'hFE, 8'hD4,
    8'hC3, 8'h27, 8'h2C, 8'h50, 8'hC4, 8'h1D, 8'hC8, 8'hFF,
    8'hD8, 8'h3A, 8'h04, 8'h3D, 8'h0B, 8'h80, 8'h5C, 8'h73, 8'hAF,
    8'hA6, 8'hBD, 8'h2B, 8'h8E, 8'h23, 8'h77, 8'h4C, 8'h7C,
    8'h79, 8'hD6, 8'h13, 8'h3C, 8'hAC, 8'h20, 8'h60, 8'hF1, 8'h14,
    8'hE3, 8'hAD, 8'h95, 8'hFB, 8'h0A, 8'h26, 8'h7F, 8'hCE,
    8'hBB, 8'h72, 8'hE7, 8'hD3, 8'h3B, 8'h09, 8'hB7, 8'h17, 8'hE5,
    8'h99, 8'hE1, 8'h24, 8'hE6, 8'h9A, 8'h48, 8'h2A, 8'hF4,
    8'h6A, 8'hF0, 8'hD1, 8'hD7, 8'h6D, 8'hDE, 8'h69, 8'hB1, 8'hFA,
    8'h59, 8'h2E, 8'h2D, 8'h45, 8'hC2, 8'h89, 8'h4A, 8'hF7,
    8'h40, 8'h91, 8'h6C, 8'hB4, 8'hC9, 8'hA9, 8'hFC, 8'h90, 8'hD2,
    8'h44, 8'h84, 8'h11, 8'hA7, 8'hFD, 8'hA4, 8'h01, 8'h12,
    8'hA8, 8'h98, 8'hF8, 8'h76, 8'hEB, 8'hCC, 8'h1A, 8'h54, 8'h0F,
    8'hAE, 8'hC6, 8'h9F, 8'h58, 8'h35, 8'hE8, 8'h87, 8'hE2,
    8'h5D, 8'hD9, 8'h97, 8'h75, 8'hD5, 8'h67, 8'h51, 8'h21, 8'hCD,
    8'h64, 8'hD0, 8'hC5, 8'h1E, 8'h25, 8'h15, 8'h57, 8'hBC,
    8'h33, 8'hE4, 8'h34, 8'h61, 8'h37, 8'hE9, 8'h39, 8'hB2, 8'hBE,
    8'h07, 8'h03, 8'h1B, 8'hED, 8'h52, 8'h22, 8'h83, 8'h38,
    8'h9B, 8'hB6, 8'hC7, 8'hDC, 8'hCF, 8'hA2, 8'hC0, 8'hF9, 8'h9C,
    8'hDF, 8'hAB, 8'h78, 8'h1F, 8'h3E, 8'h85, 8'h4F, 8'h9E, 8'h49
  };

endpackage

FILE: hw/rtl/rfpd_if.sv
// Valid/ready channel interfaces for the decrypt unit's input and result items.
// Depends on rfpd_pkg for the payload structs.
interface rfpd_in_if;
  import rfpd_pkg::*;
  logic     valid;
  logic     ready;
  rfpd_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rfpd_out_if;
  import rfpd_pkg::*;
  logic      valid;
  logic      ready;
  rfpd_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/rfpd_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies; contents are not reset.
module rfpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/rc4_feedback_packet_decrypt_unit.sv
// Top level of the plaintext-feedback RC4 packet decrypt unit.
// Depends on rfpd_pkg, rfpd_in_if / rfpd_out_if and rfpd_ram.
//
//   channel | dir | handshake              | payload
//   --------+-----+------------------------+--------------------------------------
//   in_if   | in  | valid/ready, item@both | operation, table_index, data_byte, last
//   out_if  | out | valid/ready, item@both | plain_byte, last_byte
//
// Steps: a load item or an unused code starts no state of its own. A decrypt item
//   runs states A, B and C; one that follows a decrypt is taken in the finishing
//   cycle of the one before. The serial read chain box[i] -> box[j] -> box[a+b] on
//   the single read port of the work box RAM sets that sequence of states.
// A start item copies the key table into the work box, one entry a cycle, with
//   in_ready low; the last write lands in the first idle cycle after it.
// Reset: synchronous, active low; clears control, i, j and the key table valid bits
//   (an entry never loaded reads as the built-in table). Work box is not cleared.
// Stalls: a result waits in the output register; a decrypt finishing while that
//   register is full holds in its last step until out_ready frees it.
module rc4_feedback_packet_decrypt_unit (
  input  logic      clk,
  input  logic      rst_n,
  rfpd_in_if.sink   in_if,
  rfpd_out_if.source out_if
);
  import rfpd_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_COPY = 3'd1;
  localparam logic [2:0] ST_A    = 3'd2; // box[i] back, read box[j]
  localparam logic [2:0] ST_B    = 3'd3; // box[j] back, write box[i], read box[a+b]
  localparam logic [2:0] ST_C    = 3'd4; // keystream back, write box[j], result

  logic [2:0]     state_r, state_nxt;
  logic [7:0]     i_r, j_r;
  logic [7:0]     a_r, b_r, t_r;
  logic [7:0]     cipher_r;
  logic           last_r;
  logic           fwd_hit_r;
  logic [7:0]     fwd_data_r;
  logic [7:0]     cnt_r;
  logic           copy_wr_r;
  logic [7:0]     copy_addr_r;
  logic [255:0]   key_valid_r;
  logic           out_valid_r;
  logic [7:0]     out_plain_r;
  logic           out_last_r;

  logic           out_free, in_ready, in_acc, leave_c;
  logic           acc_dec, acc_load, acc_start;
  logic [7:0]     a_cur, ks, plain;
  logic [7:0]     key_rd, box_rd;
  logic [7:0]     box_raddr, box_waddr, box_wdata;
  logic           box_we, dec_we;

  assign out_free  = !out_valid_r || out_if.ready;
  assign leave_c   = (state_r == ST_C) && out_free;
  assign in_ready  = (state_r == ST_IDLE) || leave_c;
  assign in_acc    = in_if.valid && in_ready;
  assign acc_dec   = in_acc && (in_if.data.operation == OP_DECRYPT);
  assign acc_load  = in_acc && (in_if.data.operation == OP_LOAD);
  assign acc_start = in_acc && (in_if.data.operation == OP_START);

  // box[i] read in the cycle of the previous item's box[j] write: forward it
  assign a_cur = fwd_hit_r ? fwd_data_r : box_rd;

  // keystream entry after the swap; box[j] = a is the later of the two writes
  always_comb begin
    if (t_r == j_r) begin
      ks = a_r;
    end else if (t_r == i_r) begin
      ks = b_r;
    end else begin
      ks = box_rd;
    end
  end
  assign plain = cipher_r ^ ks;

  always_comb begin
    if (acc_dec) begin
      box_raddr = i_r + 8'd1;
    end else if (state_r == ST_A) begin
      box_raddr = j_r + a_cur;
    end else if (state_r == ST_B) begin
      box_raddr = a_r + box_rd;
    end else begin
      box_raddr = t_r; // held so a stalled last step keeps its read
    end
  end

  assign dec_we = (state_r == ST_B) || leave_c;
  assign box_we = copy_wr_r || dec_we;

  always_comb begin
    if (copy_wr_r) begin
      box_waddr = copy_addr_r;
      box_wdata = key_valid_r[copy_addr_r] ? key_rd : KEY_RESET_TABLE[copy_addr_r];
    end else if (state_r == ST_B) begin
      box_waddr = i_r;
      box_wdata = box_rd;
    end else begin
      box_waddr = j_r;
      box_wdata = a_r;
    end
  end

  rfpd_ram #(.WIDTH(8), .DEPTH(BOX_DEPTH)) u_key_ram (
    .clk   (clk),
    .we    (acc_load),
    .waddr (in_if.data.table_index),
    .wdata (in_if.data.data_byte),
    .raddr (cnt_r),
    .rdata (key_rd)
  );

  rfpd_ram #(.WIDTH(8), .DEPTH(BOX_DEPTH)) u_box_ram (
    .clk   (clk),
    .we    (box_we),
    .waddr (box_waddr),
    .wdata (box_wdata),
    .raddr (box_raddr),
    .rdata (box_rd)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE, ST_C: begin
        if (state_r == ST_C && !leave_c) begin
          state_nxt = ST_C;
        end else if (acc_dec) begin
          state_nxt = ST_A;
        end else if (acc_start) begin
          state_nxt = ST_COPY;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_COPY: begin
        if (cnt_r == 8'hFF) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_A:    state_nxt = ST_B;
      ST_B:    state_nxt = ST_C;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      i_r         <= 8'd0;
      j_r         <= 8'd0;
      cnt_r       <= 8'd0;
      copy_wr_r   <= 1'b0;
      fwd_hit_r   <= 1'b0;
      key_valid_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      copy_wr_r <= (state_r == ST_COPY);
      fwd_hit_r <= leave_c && (j_r == i_r + 8'd1);

      if (state_r == ST_COPY) begin
        cnt_r <= cnt_r + 8'd1;
      end
      if (state_r == ST_A) begin
        j_r <= j_r + a_cur;
      end
      // feedback: plaintext goes into j
      if (leave_c) begin
        j_r <= j_r + plain;
      end
      if (acc_load) begin
        key_valid_r[in_if.data.table_index] <= 1'b1;
      end
      if (acc_dec) begin
        i_r <= i_r + 8'd1;
      end
      if (acc_start) begin
        i_r   <= 8'd0;
        j_r   <= 8'd0;
        cnt_r <= 8'd0;
      end

      if (leave_c) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    copy_addr_r <= cnt_r;
    if (acc_dec) begin
      cipher_r <= in_if.data.data_byte;
      last_r   <= in_if.data.last;
    end
    if (state_r == ST_A) begin
      a_r <= a_cur;
    end
    if (state_r == ST_B) begin
      b_r <= box_rd;
      t_r <= a_r + box_rd;
    end
    if (leave_c) begin
      fwd_data_r  <= a_r;
      out_plain_r <= plain;
      out_last_r  <= last_r;
    end
  end

  assign in_if.ready          = in_ready;
  assign out_if.valid         = out_valid_r;
  assign out_if.data.plain_byte = out_plain_r;
  assign out_if.data.last_byte  = out_last_r;

  // copy writes and swap writes never share the box write port
  a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(copy_wr_r && dec_we))
    else $error("box write port conflict");

  // no item is taken in the copy state
  a_copy_block: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COPY) |-> !in_ready)
    else $error("item accepted during copy");

  // an accepted decrypt starts its read chain next cycle
  a_dec_start: assert property (@(posedge clk) disable iff (!rst_n)
    acc_dec |=> (state_r == ST_A))
    else $error("decrypt did not enter read chain");

  // a result appears only from the finishing step
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_C))
    else $error("result loaded outside last step");

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for rc4_feedback_packet_decrypt_unit: directed rows, then random packets.
// Depends on rfpd_pkg, rfpd_in_if / rfpd_out_if and the unit's RTL.
// A local keystream model predicts every plain byte and checks it field by field.
module tb_top;
  import rfpd_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int HOLD_CYCLES     = 400;   // long receiver hold-off
  localparam int STALL_LIMIT     = 5000;  // cycles with no item moving
  localparam int END_CYCLES      = 300;   // covers a start copy still running
  localparam int ITEMS_PER_PHASE = 480;

  typedef struct {
    rfpd_in_t  item;
    bit        typed;
    rfpd_out_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  rfpd_in_if  in_ch ();
  rfpd_out_if out_ch ();

  rc4_feedback_packet_decrypt_unit u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch)
  );

  // keystream model state
  logic [7:0] key_bytes [0:BOX_DEPTH-1];
  logic [7:0] perm_box  [0:BOX_DEPTH-1];
  logic [7:0] idx_i;
  logic [7:0] idx_j;
  rfpd_out_t  plain_expected [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_request  = 1'b0;
  int error_count   = 0;
  int results_seen  = 0;
  int sent_count    = 0;
  int decrypt_count = 0;
  int start_count   = 0;
  int load_count    = 0;
  int ignored_count = 0;
  int hold_count    = 0;
  int idle_cycles   = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // one RC4 step with plaintext fed back into j
  function automatic logic [7:0] decrypt_next(input logic [7:0] cipher);
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] ks_idx;
    logic [7:0] plain;
    idx_i = idx_i + 8'd1;
    a = perm_box[idx_i];
    idx_j = idx_j + a;
    b = perm_box[idx_j];
    perm_box[idx_i] = b;
    perm_box[idx_j] = a;
    ks_idx = a + b;
    plain = cipher ^ perm_box[ks_idx];
    idx_j = idx_j + plain;
    return plain;
  endfunction

  function automatic rfpd_in_t mk_item(input logic [1:0] op, input logic [7:0] idx,
                                       input logic [7:0] data, input logic last);
    rfpd_in_t it;
    it.operation   = op;
    it.table_index = idx;
    it.data_byte   = data;
    it.last        = last;
    return it;
  endfunction

  function automatic dir_row_t mk_row(input logic [1:0] op, input logic [7:0] idx,
                                      input logic [7:0] data, input logic last,
                                      input bit typed, input logic [7:0] plain,
                                      input logic last_out);
    dir_row_t r;
    r.item            = mk_item(op, idx, data, last);
    r.typed           = typed;
    r.want.plain_byte = plain;
    r.want.last_byte  = last_out;
    return r;
  endfunction

  // update the model for an accepted item; a typed value replaces the prediction
  task automatic apply_item(input rfpd_in_t it, input bit typed, input rfpd_out_t want);
    rfpd_out_t r;
    case (it.operation)
      OP_LOAD: begin
        key_bytes[it.table_index] = it.data_byte;
        load_count++;
      end
      OP_START: begin
        perm_box = key_bytes;
        idx_i = 8'd0;
        idx_j = 8'd0;
        start_count++;
      end
      OP_DECRYPT: begin
        r.plain_byte = decrypt_next(it.data_byte);
        r.last_byte  = it.last;
        plain_expected.push_back(typed ? want : r);
        decrypt_count++;
      end
      default: ignored_count++;
    endcase
  endtask

  task automatic send_item(input rfpd_in_t it, input bit typed, input rfpd_out_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    apply_item(it, typed, want);
    if (it.operation != OP_UNUSED) sent_count++;
  endtask

  task automatic send_plain(input logic [1:0] op, input logic [7:0] idx,
                            input logic [7:0] data, input logic last);
    send_item(mk_item(op, idx, data, last), 1'b0, '0);
  endtask

  // sender pause: nothing offered until every expected byte is back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (plain_expected.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch: %s got %0h want %0h (result %0d)", what, got, want, results_seen);
    error_count++;
  endtask

  task automatic check_result(input rfpd_out_t got);
    rfpd_out_t want;
    if (plain_expected.size() == 0) begin
      report_mismatch("unexpected result, plain_byte", got.plain_byte, 0);
    end else begin
      want = plain_expected.pop_front();
      if (got.plain_byte !== want.plain_byte)
        report_mismatch("plain_byte", got.plain_byte, want.plain_byte);
      if (got.last_byte !== want.last_byte)
        report_mismatch("last_byte", got.last_byte, want.last_byte);
    end
    results_seen++;
  endtask

  // one random packet: optional key loads, a start, then cipher bytes with some noise
  task automatic run_packet(input bit with_hold);
    int n_loads;
    int len;
    int pick;
    bit drop_last;
    logic last;
    n_loads = ($urandom_range(0, 99) < 60) ? 0 : $urandom_range(1, 6);
    repeat (n_loads)
      send_plain(OP_LOAD, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)));
    send_plain(OP_START, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               1'($urandom_range(0, 1)));
    if (with_hold) begin
      hold_request = 1'b1;
      hold_count++;
    end
    pick = $urandom_range(0, 99);
    if (with_hold)      len = 40;
    else if (pick < 85) len = $urandom_range(1, 24);
    else if (pick < 97) len = $urandom_range(25, 80);
    else                len = $urandom_range(250, 300);  // i wraps past 255 when len exceeds 255
    drop_last = ($urandom_range(0, 99) < 8);
    for (int k = 0; k < len; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 4)
        send_plain(OP_UNUSED, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)));
      else if (pick < 7)  // stray load mid packet leaves the work box alone
        send_plain(OP_LOAD, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)));
      last = ((k == len - 1) && !drop_last) || ($urandom_range(0, 99) < 3);
      send_plain(OP_DECRYPT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), last);
    end
  endtask

  // result side: random ready, plus a long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      check_result(out_ch.data);
  end

  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", idle_cycles);
      $display("tb_top: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    dir_row_t directed_rows [$];
    int phase_base;
    int pkt_in_phase;

    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    key_bytes = KEY_RESET_TABLE;
    foreach (perm_box[k]) perm_box[k] = 8'h00;
    idx_i = 8'd0;
    idx_j = 8'd0;

    // reset table: first keystream byte is box[0x8C + 0x3B] = 0x58
    directed_rows.push_back(mk_row(OP_START,   8'h00, 8'h00, 1'b0, 0, 8'h00, 1'b0));
    directed_rows.push_back(mk_row(OP_DECRYPT, 8'h00, 8'h00, 1'b0, 1, 8'h58, 1'b0));
    directed_rows.push_back(mk_row(OP_DECRYPT, 8'hFF, 8'hFF, 1'b1, 0, 8'h00, 1'b0));
    // bytes after a last mark keep the same keystream
    directed_rows.push_back(mk_row(OP_DECRYPT, 8'h00, 8'hA5, 1'b0, 0, 8'h00, 1'b0));
    directed_rows.push_back(mk_row(OP_UNUSED,  8'hFF, 8'hFF, 1'b1, 0, 8'h00, 1'b0));
    directed_rows.push_back(mk_row(OP_UNUSED,  8'h00, 8'h00, 1'b0, 0, 8'h00, 1'b0));
    // box[0] = box[1] = 0: first keystream byte is zero, plain equals cipher
    directed_rows.push_back(mk_row(OP_LOAD,    8'h00, 8'h00, 1'b0, 0, 8'h00, 1'b0));
    directed_rows.push_back(mk_row(OP_LOAD,    8'h01, 8'h00, 1'b1, 0, 8'h00, 1'b0));
    directed_rows.push_back(mk_row(OP_LOAD,    8'hFF, 8'hFF, 1'b0, 0, 8'h00, 1'b0));
    directed_rows.push_back(mk_row(OP_START,   8'hAA, 8'h55, 1'b1, 0, 8'h00, 1'b0));
    directed_rows.push_back(mk_row(OP_DECRYPT, 8'h00, 8'hFF, 1'b1, 1, 8'hFF, 1'b1));
    directed_rows.push_back(mk_row(OP_DECRYPT, 8'h00, 8'h00, 1'b0, 0, 8'h00, 1'b0));
    directed_rows.push_back(mk_row(OP_DECRYPT, 8'h00, 8'h80, 1'b1, 0, 8'h00, 1'b0));
    // a load inside a packet must not touch the running box
    directed_rows.push_back(mk_row(OP_LOAD,    8'h80, 8'h55, 1'b1, 0, 8'h00, 1'b0));
    directed_rows.push_back(mk_row(OP_DECRYPT, 8'h00, 8'h7F, 1'b0, 0, 8'h00, 1'b0));
    directed_rows.push_back(mk_row(OP_LOAD,    8'h00, 8'hFF, 1'b0, 0, 8'h00, 1'b0));
    directed_rows.push_back(mk_row(OP_START,   8'h00, 8'h00, 1'b0, 0, 8'h00, 1'b0));
    directed_rows.push_back(mk_row(OP_DECRYPT, 8'h00, 8'h01, 1'b0, 0, 8'h00, 1'b0));
    directed_rows.push_back(mk_row(OP_DECRYPT, 8'hFF, 8'hFE, 1'b0, 0, 8'h00, 1'b0));
    directed_rows.push_back(mk_row(OP_DECRYPT, 8'h00, 8'hFF, 1'b1, 0, 8'h00, 1'b0));
    directed_rows.push_back(mk_row(OP_UNUSED,  8'h5A, 8'hA5, 1'b0, 0, 8'h00, 1'b0));
    directed_rows.push_back(mk_row(OP_DECRYPT, 8'h00, 8'h00, 1'b1, 0, 8'h00, 1'b0));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r])
      send_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want);
    drain_results();

    // sender/receiver idle mix: 22/71, then 71/22, then none
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 22 : (phase == 1) ? 71 : 0;
      recv_idle_pct = (phase == 0) ? 71 : (phase == 1) ? 22 : 0;
      phase_base    = sent_count;
      pkt_in_phase  = 0;
      while (sent_count - phase_base < ITEMS_PER_PHASE) begin
        run_packet(pkt_in_phase == 3);
        pkt_in_phase++;
        if ($urandom_range(0, 99) < 4) drain_results();
      end
      drain_results();
    end

    repeat (END_CYCLES) @(posedge clk);
    if (plain_expected.size() != 0)
      report_mismatch("bytes never returned, count", 0, plain_expected.size());

    $display("covered %0d items: %0d decrypts, %0d starts, %0d loads, %0d unused codes",
             sent_count + ignored_count, decrypt_count, start_count, load_count, ignored_count);
    $display("checked %0d plain bytes, %0d long receiver hold-offs, %0d mismatches",
             results_seen, hold_count, error_count);
    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/rfpd_pkg.sv
hw/rtl/rfpd_if.sv
hw/rtl/rfpd_ram.sv
hw/rtl/rc4_feedback_packet_decrypt_unit.sv
bench/tb_top.sv
